### rtl/ltric_pkg.sv
package ltric_pkg;

   // Operator codes held as the pending operator
   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MOD = 3'd4
   } op_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ITER,
      ST_APPLY,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_DIGIT,
      CMD_LATCH,
      CMD_STEP,
      CMD_APPLY,
      CMD_EMIT
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type kind;
   } dp_ctrl_type;

   typedef struct packed {
      logic is_digit;
      logic is_operator;
      logic pend_slow;
   } dp_status_type;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int OUT_BITS = 32;

   function automatic logic char_is_operator(input logic [7:0] c);
      logic r;
      r = (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) ||
          (c == CHAR_SLASH) || (c == CHAR_PCT);
      return r;
   endfunction

   function automatic op_type char_to_op(input logic [7:0] c);
      op_type r;
      r = OP_ADD;
      case (c)
         CHAR_MINUS: r = OP_SUB;
         CHAR_STAR:  r = OP_MUL;
         CHAR_SLASH: r = OP_DIV;
         CHAR_PCT:   r = OP_MOD;
         default:    r = OP_ADD;
      endcase
      return r;
   endfunction

endpackage

### rtl/ltric_dp.sv
module ltric_dp #(
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ltric_pkg::dp_ctrl_type         ctrl,
   output ltric_pkg::dp_status_type       status,
   input  logic                           req_action,
   input  logic [7:0]                     req_ch,
   output logic [ltric_pkg::OUT_BITS-1:0] rsp_value
);

   logic [VALUE_BITS-1:0]             total_ff, total_in;
   logic [VALUE_BITS-1:0]             cur_ff, cur_in;
   logic [VALUE_BITS-1:0]             acc_ff, acc_in;
   ltric_pkg::op_type                 pend_ff, pend_in;
   ltric_pkg::op_type                 next_op_ff, next_op_in;
   logic [ltric_pkg::OUT_BITS-1:0]    value_ff, value_in;

   logic [VALUE_BITS:0]               rem_shift;
   logic [VALUE_BITS:0]               diff;
   logic                              ge;
   logic                              div_zero;

   assign status.is_digit    = (req_ch >= ltric_pkg::CHAR_ZERO) &&
                               (req_ch <= ltric_pkg::CHAR_NINE);
   assign status.is_operator = ltric_pkg::char_is_operator(req_ch);
   assign status.pend_slow   = (pend_ff == ltric_pkg::OP_MUL) ||
                               (pend_ff == ltric_pkg::OP_DIV) ||
                               (pend_ff == ltric_pkg::OP_MOD);

   // one restoring divide step
   assign rem_shift = {acc_ff, total_ff[VALUE_BITS-1]};
   assign diff      = rem_shift - {1'b0, cur_ff};
   assign ge        = ~diff[VALUE_BITS];
   assign div_zero  = (cur_ff == '0);

   always_comb begin
      total_in   = total_ff;
      cur_in     = cur_ff;
      acc_in     = acc_ff;
      pend_in    = pend_ff;
      next_op_in = next_op_ff;
      value_in   = value_ff;
      case (ctrl.kind)
         ltric_pkg::CMD_DIGIT: begin
            cur_in = (cur_ff << 3) + (cur_ff << 1) + VALUE_BITS'(req_ch[3:0]);
         end
         ltric_pkg::CMD_LATCH: begin
            acc_in     = '0;
            next_op_in = req_action ? ltric_pkg::OP_ADD : ltric_pkg::char_to_op(req_ch);
         end
         ltric_pkg::CMD_STEP: begin
            if (pend_ff == ltric_pkg::OP_MUL) begin
               // shift-add multiply: total is the multiplicand, cur the multiplier
               acc_in   = acc_ff + (cur_ff[0] ? total_ff : '0);
               total_in = total_ff << 1;
               cur_in   = cur_ff >> 1;
            end else begin
               acc_in   = ge ? diff[VALUE_BITS-1:0] : rem_shift[VALUE_BITS-1:0];
               total_in = {total_ff[VALUE_BITS-2:0], ge};
            end
         end
         ltric_pkg::CMD_APPLY: begin
            case (pend_ff)
               ltric_pkg::OP_ADD: total_in = total_ff + cur_ff;
               ltric_pkg::OP_SUB: total_in = total_ff - cur_ff;
               ltric_pkg::OP_MUL: total_in = acc_ff;
               ltric_pkg::OP_DIV: total_in = div_zero ? '0 : total_ff;
               ltric_pkg::OP_MOD: total_in = div_zero ? '0 : acc_ff;
               default:           total_in = total_ff;
            endcase
            cur_in  = '0;
            pend_in = next_op_ff;
         end
         ltric_pkg::CMD_EMIT: begin
            value_in = ltric_pkg::OUT_BITS'(total_ff);
            total_in = '0;
            cur_in   = '0;
            pend_in  = ltric_pkg::OP_ADD;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         cur_ff   <= '0;
         pend_ff  <= ltric_pkg::OP_ADD;
      end else begin
         total_ff <= total_in;
         cur_ff   <= cur_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      next_op_ff <= next_op_in;
      value_ff   <= value_in;
   end

   assign rsp_value = value_ff;

endmodule

### rtl/ltric_ctrl.sv
module ltric_ctrl #(
   parameter int VALUE_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_action,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  ltric_pkg::dp_status_type status,
   output ltric_pkg::dp_ctrl_type   ctrl
);

   localparam int CntW = $clog2(VALUE_BITS);
   localparam logic [CntW-1:0] CntLast = CntW'(VALUE_BITS - 1);

   ltric_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 end_ff, end_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ltric_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl.kind    = ltric_pkg::CMD_NONE;
      unique case (state_ff)
         ltric_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_action || (!status.is_digit && status.is_operator)) begin
                  end_in    = req_action;
                  cnt_in    = '0;
                  ctrl.kind = ltric_pkg::CMD_LATCH;
                  state_in  = status.pend_slow ? ltric_pkg::ST_ITER : ltric_pkg::ST_APPLY;
               end else if (status.is_digit) begin
                  ctrl.kind = ltric_pkg::CMD_DIGIT;
               end
            end
         end
         ltric_pkg::ST_ITER: begin
            ctrl.kind = ltric_pkg::CMD_STEP;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CntLast) begin
               state_in = ltric_pkg::ST_APPLY;
            end
         end
         ltric_pkg::ST_APPLY: begin
            ctrl.kind = ltric_pkg::CMD_APPLY;
            state_in  = end_ff ? ltric_pkg::ST_EMIT : ltric_pkg::ST_IDLE;
         end
         ltric_pkg::ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl.kind    = ltric_pkg::CMD_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ltric_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ltric_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltric_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         end_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         end_ff       <= end_in;
      end
   end

endmodule

### rtl/left_to_right_integer_calculator_unit.sv
// Left-to-right integer calculator. Feed an expression one ASCII character per
// item (req_action low); digits build the current number, and each of + - * / %
// applies the pending operator to the running total, strictly left to right with
// no precedence. Any other character is dropped. An item with req_action high
// ends the expression: the pending operator is applied and one result item
// carries the total on rsp_value, after which the state is back to zero with
// a pending add. Arithmetic is unsigned and wraps at VALUE_BITS; divide or
// modulo by zero gives 0; only the low 32 bits of the total are returned.
// Sequence: a digit or an ignored character is taken while idle. An operator
// or end item goes through ST_APPLY, first through ST_ITER when the pending
// operator is *, / or %, where the shared shift-add multiplier and restoring
// divider retire one bit per cycle. An end item then goes through ST_EMIT to
// load the output register; req_stall is high while an item is in work. A
// waiting result does not block new characters, only the next end item's final
// load.

module left_to_right_integer_calculator_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [7:0]                     req_ch,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ltric_pkg::OUT_BITS-1:0] rsp_value
);

   ltric_pkg::dp_ctrl_type   ctrl;
   ltric_pkg::dp_status_type status;

   // sequencer: accepts items, counts iteration steps, owns the result valid
   ltric_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .ctrl       (ctrl)
   );

   // datapath: total, current number, pending operator, shared mul/div unit
   ltric_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_action (req_action),
      .req_ch     (req_ch),
      .rsp_value  (rsp_value)
   );

endmodule
